// ----- rtl/bmc_pkg.sv -----
// Shared constants, types and helpers of the binary mask centroid block
`timescale 1ns / 1ps

package bmc_pkg;

	// frame geometry limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// field and state widths
	localparam int PIX_W      = 8;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int COORD_W    = 10;
	localparam int SUM_W      = 30;
	localparam int CNT_W      = 21;

	// value of a set mask pixel
	localparam logic [PIX_W-1:0] SET_VALUE = 8'd255;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// register reset values
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd704;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd576;

	// totals queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// restoring divider: one quotient bit per step
	localparam int DIV_STEPS = COORD_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// totals of one finished frame
	typedef struct packed {
		logic [SUM_W-1:0] sum_x;
		logic [SUM_W-1:0] sum_y;
		logic [CNT_W-1:0] count;
	} bmc_totals_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} bmc_q_status_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_HOLD
	} bmc_back_state_t;

	// last valid index for a size register, with zero read as one and
	// values above the limit read as the limit
	function automatic logic [COORD_W-1:0] last_index(input logic [CFG_W-1:0] size,
			input logic [CFG_W-1:0] limit);
		logic [CFG_W-1:0] s;
		if (size == '0) begin
			s = CFG_W'(1);
		end else if (size > limit) begin
			s = limit;
		end else begin
			s = size;
		end
		return COORD_W'(s - CFG_W'(1));
	endfunction

endpackage

// ----- rtl/bmc_ifs.sv -----
// Valid/ready channel interfaces for mask pixels and centroid results
`timescale 1ns / 1ps

interface bmc_px_if import bmc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface bmc_ctr_if import bmc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] centroid_x;
	logic [COORD_W-1:0] centroid_y;
	logic [CNT_W-1:0]   pixel_count;
	logic               found;

	modport source (output valid, output centroid_x, output centroid_y,
		output pixel_count, output found, input ready);
	modport sink (input valid, input centroid_x, input centroid_y,
		input pixel_count, input found, output ready);
endinterface

// ----- rtl/bmc_front.sv -----
// Front end: frame size registers, raster position tracking and coordinate sums
`timescale 1ns / 1ps

module bmc_front import bmc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	bmc_px_if.sink               px,
	input  bmc_q_status_t        q_status,
	output logic                 push,
	output bmc_totals_t          push_data
);

	logic [CFG_W-1:0]   frame_width_q;
	logic [CFG_W-1:0]   frame_height_q;
	logic [COORD_W-1:0] column_q;
	logic [COORD_W-1:0] row_q;
	logic [SUM_W-1:0]   sum_x_q;
	logic [SUM_W-1:0]   sum_y_q;
	logic [CNT_W-1:0]   count_q;

	logic               accept;
	logic               hit;
	logic [COORD_W-1:0] last_col;
	logic [COORD_W-1:0] last_row;
	logic               row_end;
	logic               frame_end;
	bmc_totals_t        totals_nxt;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// take a pixel whenever the queue has room for a frame's totals
	assign px.ready = !q_status.full;
	assign accept   = px.valid && px.ready;
	assign hit      = (px.pixel == SET_VALUE);

	// end of row and end of frame tests
	assign last_col  = last_index(frame_width_q, CFG_W'(MAX_WIDTH));
	assign last_row  = last_index(frame_height_q, CFG_W'(MAX_HEIGHT));
	assign row_end   = (column_q >= last_col);
	assign frame_end = row_end && (row_q >= last_row);

	// running totals including the current pixel
	always_comb begin
		totals_nxt.sum_x = sum_x_q;
		totals_nxt.sum_y = sum_y_q;
		totals_nxt.count = count_q;
		if (hit) begin
			totals_nxt.sum_x = sum_x_q + SUM_W'(column_q);
			totals_nxt.sum_y = sum_y_q + SUM_W'(row_q);
			totals_nxt.count = count_q + CNT_W'(1);
		end
	end

	assign push      = accept && frame_end;
	assign push_data = totals_nxt;

	// position and sums, cleared after the last pixel of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			count_q  <= '0;
		end else if (accept) begin
			if (frame_end) begin
				column_q <= '0;
				row_q    <= '0;
				sum_x_q  <= '0;
				sum_y_q  <= '0;
				count_q  <= '0;
			end else begin
				sum_x_q <= totals_nxt.sum_x;
				sum_y_q <= totals_nxt.sum_y;
				count_q <= totals_nxt.count;
				if (row_end) begin
					column_q <= '0;
					row_q    <= row_q + COORD_W'(1);
				end else begin
					column_q <= column_q + COORD_W'(1);
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_clear_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (count_q == '0 && sum_x_q == '0 && sum_y_q == '0))
		else $error("totals not cleared after frame end");

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !q_status.full)
		else $error("pixel accepted while totals queue full");

	a_push_needs_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (px.valid && row_end))
		else $error("frame totals pushed without an ending pixel");
`endif

endmodule

// ----- rtl/bmc_queue.sv -----
// Two-entry queue of frame totals between the front and back ends
`timescale 1ns / 1ps

module bmc_queue import bmc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bmc_totals_t   push_data,
	input  logic          pop,
	output bmc_totals_t   head,
	output bmc_q_status_t status
);

	bmc_totals_t     entry_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] fill_q;

	assign status.full  = (fill_q == Q_CW'(Q_DEPTH));
	assign status.empty = (fill_q == '0);
	assign head         = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_AW'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + Q_CW'(1);
				2'b01:   fill_q <= fill_q - Q_CW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full))
		else $error("push into full totals queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && status.empty))
		else $error("pop from empty totals queue");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= Q_CW'(Q_DEPTH))
		else $error("totals queue fill level out of range");
`endif

endmodule

// ----- rtl/bmc_back.sv -----
// Back end: restoring divider for the mean coordinates and the result register
`timescale 1ns / 1ps

module bmc_back import bmc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  bmc_totals_t   head,
	input  bmc_q_status_t q_status,
	output logic          pop,
	bmc_ctr_if.source     ctr
);

	bmc_back_state_t    state_q;
	bmc_back_state_t    state_nxt;
	logic [STEP_W-1:0]  step_q;
	logic [SUM_W-1:0]   rem_x_q;
	logic [SUM_W-1:0]   rem_y_q;
	logic [SUM_W-1:0]   div_q;
	logic [COORD_W-1:0] quot_x_q;
	logic [COORD_W-1:0] quot_y_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               out_valid_q;
	logic [COORD_W-1:0] out_x_q;
	logic [COORD_W-1:0] out_y_q;
	logic [CNT_W-1:0]   out_cnt_q;
	logic               out_found_q;

	logic               load_out;
	logic               last_step;
	logic               ge_x;
	logic               ge_y;
	logic               cnt_nz;

	assign last_step = (step_q == STEP_W'(DIV_STEPS - 1));
	assign ge_x      = (rem_x_q >= div_q);
	assign ge_y      = (rem_y_q >= div_q);
	assign cnt_nz    = (cnt_q != '0);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			B_IDLE: if (!q_status.empty) state_nxt = B_DIV;
			B_DIV:  if (last_step) state_nxt = B_HOLD;
			B_HOLD: if (!out_valid_q || ctr.ready) state_nxt = B_IDLE;
			default: state_nxt = B_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			B_IDLE:  pop = !q_status.empty;
			B_HOLD:  load_out = !out_valid_q || ctr.ready;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (pop) begin
				step_q <= '0;
			end else if (state_q == B_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (ctr.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// divider datapath: divisor starts at count shifted to the top quotient bit
	always_ff @(posedge clk) begin
		if (pop) begin
			rem_x_q  <= head.sum_x;
			rem_y_q  <= head.sum_y;
			div_q    <= SUM_W'({head.count, {(COORD_W - 1){1'b0}}});
			cnt_q    <= head.count;
			quot_x_q <= '0;
			quot_y_q <= '0;
		end else if (state_q == B_DIV) begin
			if (ge_x) begin
				rem_x_q <= rem_x_q - div_q;
			end
			if (ge_y) begin
				rem_y_q <= rem_y_q - div_q;
			end
			quot_x_q <= {quot_x_q[COORD_W-2:0], ge_x};
			quot_y_q <= {quot_y_q[COORD_W-2:0], ge_y};
			div_q    <= div_q >> 1;
		end
	end

	// result register; an empty frame reports zeros
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_x_q     <= cnt_nz ? quot_x_q : '0;
			out_y_q     <= cnt_nz ? quot_y_q : '0;
			out_cnt_q   <= cnt_q;
			out_found_q <= cnt_nz;
		end
	end

	assign ctr.valid       = out_valid_q;
	assign ctr.centroid_x  = out_x_q;
	assign ctr.centroid_y  = out_y_q;
	assign ctr.pixel_count = out_cnt_q;
	assign ctr.found       = out_found_q;

`ifndef SYNTHESIS
	a_empty_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |-> (out_x_q == '0 && out_y_q == '0 && out_cnt_q == '0))
		else $error("empty frame result carries nonzero fields");

	a_found_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_found_q) |-> (out_cnt_q != '0))
		else $error("found result with zero count");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == B_DIV && step_q == '0))
		else $error("divider not started after pop");

	a_hold_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV && last_step) |=> (state_q == B_HOLD))
		else $error("divider did not finish after last step");
`endif

endmodule

// ----- rtl/binary_mask_centroid.sv -----
// Top level of the binary mask centroid block
`timescale 1ns / 1ps

// Takes one 8-bit mask pixel per clock in raster order, unless the input is
// stalled; a pixel counts as set only at value 255. The frame size comes from
// frame_width (index 0) and frame_height (index 1); zero reads as one and
// values above 1024 read as 1024. After the last pixel of a frame one result
// gives the truncated mean column and row of the set pixels, their count and
// a found flag (all zero when no pixel was set). The front end accepts one
// pixel every cycle while the queue has room; frame totals go through a
// two-entry queue to a ten-step restoring divider. A frame's totals are
// popped from the queue, go through ten divide steps and are then loaded into
// the output register. The back end works on one frame's totals at a time,
// so the input stalls only when two frames' totals are waiting in the
// queue.
module binary_mask_centroid import bmc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	bmc_px_if.sink               px_in,
	bmc_ctr_if.source            ctr_out
);

	logic          push;
	bmc_totals_t   push_data;
	logic          pop;
	bmc_totals_t   head;
	bmc_q_status_t q_status;

	// pixel accumulation
	bmc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.px        (px_in),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	// frame totals queue
	bmc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	// division and result
	bmc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.ctr      (ctr_out)
	);

endmodule

// ----- test/tb_binary_mask_centroid.sv -----
// Self-checking testbench of the binary mask centroid block with a per-pixel predictor
`timescale 1ns / 1ps

module tb_binary_mask_centroid;
	import bmc_pkg::*;

	localparam int RANDOM_PIXELS = 250;
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_CYCLES  = 30;
	localparam int STALL_LIMIT   = 2000;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [CNT_W-1:0]   count;
		logic               found;
	} centroid_t;

	// tracks frame position and coordinate sums, queues one centroid per frame
	class centroid_scoreboard;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		int               col_pos;
		int               row_pos;
		longint unsigned  col_sum;
		longint unsigned  row_sum;
		longint unsigned  set_pixels;
		centroid_t        frame_results[$];
		int               errors;

		function new();
			width_reg  = FRAME_WIDTH_RST;
			height_reg = FRAME_HEIGHT_RST;
			col_pos    = 0;
			row_pos    = 0;
			col_sum    = 0;
			row_sum    = 0;
			set_pixels = 0;
			errors     = 0;
		endfunction

		function void write_size(input logic [CFG_IDX_W-1:0] reg_index,
				input logic [CFG_W-1:0] value);
			if (reg_index == REG_FRAME_WIDTH) begin
				width_reg = value;
			end else begin
				height_reg = value;
			end
		endfunction

		// zero reads as one, anything above the limit reads as the limit
		function int eff_size(input logic [CFG_W-1:0] value, input int limit);
			if (value == '0)
				return 1;
			if (int'(value) > limit)
				return limit;
			return int'(value);
		endfunction

		function int pending();
			return frame_results.size();
		endfunction

		function void note_pixel(input logic [PIX_W-1:0] value);
			int        w;
			int        h;
			logic      row_end;
			logic      frame_end;
			centroid_t res;
			w = eff_size(width_reg, MAX_WIDTH);
			h = eff_size(height_reg, MAX_HEIGHT);
			if (value == SET_VALUE) begin
				col_sum += col_pos;
				row_sum += row_pos;
				set_pixels++;
			end
			// a position already past a shrunk size ends its row or frame here
			row_end   = (col_pos >= w - 1);
			frame_end = row_end && (row_pos >= h - 1);
			if (row_end) begin
				col_pos = 0;
				row_pos++;
			end else begin
				col_pos++;
			end
			if (frame_end) begin
				if (set_pixels > 0) begin
					res.cx    = COORD_W'(col_sum / set_pixels);
					res.cy    = COORD_W'(row_sum / set_pixels);
					res.count = CNT_W'(set_pixels);
					res.found = 1'b1;
				end else begin
					res = '0;
				end
				frame_results.push_back(res);
				col_pos    = 0;
				row_pos    = 0;
				col_sum    = 0;
				row_sum    = 0;
				set_pixels = 0;
			end
		endfunction

		function void check_field(input string name, input int unsigned want,
				input int unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(input centroid_t got);
			centroid_t want;
			if (frame_results.size() == 0) begin
				$display("%0t: result with no frame pending, expected none actual x=%0d y=%0d n=%0d f=%0d",
					$time, got.cx, got.cy, got.count, got.found);
				errors++;
				return;
			end
			want = frame_results.pop_front();
			check_field("centroid_x", want.cx, got.cx);
			check_field("centroid_y", want.cy, got.cy);
			check_field("pixel_count", want.count, got.count);
			check_field("found", want.found, got.found);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   gap_pct;
	int                   stall_pct;
	int                   quiet_cycles = 0;
	centroid_scoreboard   sb = new();

	bmc_px_if  px_ch ();
	bmc_ctr_if ctr_ch ();

	binary_mask_centroid u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.px_in     (px_ch),
		.ctr_out   (ctr_ch)
	);

	always #2 clk = ~clk;

	// result side back-pressure
	always @(posedge clk) begin
		ctr_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// request monitors and stall watchdog
	always @(posedge clk) begin
		centroid_t seen;
		if (arst_n) begin
			if (px_ch.valid && px_ch.ready)
				sb.note_pixel(px_ch.pixel);
			if (ctr_ch.valid && ctr_ch.ready) begin
				seen.cx    = ctr_ch.centroid_x;
				seen.cy    = ctr_ch.centroid_y;
				seen.count = ctr_ch.pixel_count;
				seen.found = ctr_ch.found;
				sb.check_result(seen);
			end
			if ((px_ch.valid && px_ch.ready) || (ctr_ch.valid && ctr_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("binary_mask_centroid: mismatch");
				$finish;
			end
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				gap_pct   = 70;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				gap_pct   = 0;
				stall_pct = 70;
			end
			default: begin
				gap_pct   = 13;
				stall_pct = 13;
			end
		endcase
	endtask

	// both size registers, written back to back
	task automatic set_frame(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
		sb.write_size(REG_FRAME_WIDTH, cols);
		sb.write_size(REG_FRAME_HEIGHT, rows);
		cfg_en    <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= cols;
		@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data  <= rows;
		@(posedge clk);
		cfg_en <= 1'b0;
	endtask

	// one pixel request, with random gaps before it
	task automatic push_pixel(input logic [PIX_W-1:0] value);
		while ($urandom_range(99) < gap_pct) begin
			px_ch.valid <= 1'b0;
			@(posedge clk);
		end
		px_ch.valid <= 1'b1;
		px_ch.pixel <= value;
		@(posedge clk);
		while (!px_ch.ready)
			@(posedge clk);
	endtask

	// hot_from >= 0: only pixels from that index on are set, else random by density
	task automatic send_pixels(input int count, input int density, input int hot_from);
		logic [PIX_W-1:0] value;
		for (int i = 0; i < count; i++) begin
			if (hot_from >= 0)
				value = (i >= hot_from) ? SET_VALUE : PIX_W'($urandom_range(0, 254));
			else if ($urandom_range(99) < density)
				value = SET_VALUE;
			else
				value = PIX_W'($urandom_range(0, 255));
			push_pixel(value);
		end
	endtask

	// stop sending, let the monitor see the last request, then drain and settle
	task automatic wait_idle();
		px_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int w_cfg;
		int h_cfg;
		int cols;
		int rows;
		int frames;
		int partial;
		int phase;
		int random_sent;
		arst_n       = 1'b0;
		cfg_en       = 1'b0;
		cfg_index    = REG_FRAME_WIDTH;
		cfg_data     = '0;
		px_ch.valid  = 1'b0;
		px_ch.pixel  = '0;
		ctr_ch.ready = 1'b0;
		gap_pct      = 0;
		stall_pct    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero sizes act as one: every pixel is a frame, set only at 255
		set_frame('0, '0);
		push_pixel(SET_VALUE);
		push_pixel(8'd0);
		push_pixel(8'd254);
		push_pixel(8'd127);
		push_pixel(8'd128);
		push_pixel(8'd1);
		wait_idle();

		// small frame with a mix of set and clear pixels
		set_frame(11'd3, 11'd2);
		push_pixel(SET_VALUE);
		push_pixel(8'd0);
		push_pixel(SET_VALUE);
		push_pixel(8'd0);
		push_pixel(SET_VALUE);
		push_pixel(SET_VALUE);
		wait_idle();

		// size shrinks mid-frame: the next pixel ends the frame
		set_frame(11'd4, 11'd3);
		repeat (5) push_pixel(SET_VALUE);
		wait_idle();
		set_frame(11'd2, 11'd1);
		push_pixel(SET_VALUE);
		wait_idle();

		// widest frame, only the last column set
		phase = 0;
		set_idling(idle_mode_t'(phase % 4));
		set_frame(11'd1024, 11'd1);
		send_pixels(1024, 0, 1023);
		wait_idle();

		// over-range width, cut short by a shrink
		phase++;
		set_idling(idle_mode_t'(phase % 4));
		set_frame(11'd2047, 11'd1);
		send_pixels(10, 50, -1);
		wait_idle();
		set_frame(11'd1, 11'd1);
		push_pixel(SET_VALUE);
		wait_idle();

		// over-range height, cut short by a shrink
		phase++;
		set_idling(idle_mode_t'(phase % 4));
		set_frame(11'd1, 11'd2047);
		send_pixels(100, 50, -1);
		wait_idle();
		set_frame(11'd1, 11'd1);
		push_pixel(SET_VALUE);
		wait_idle();

		// random phases of small frames, some left unfinished
		random_sent = 0;
		while (random_sent < RANDOM_PIXELS) begin
			phase++;
			set_idling(idle_mode_t'(phase % 4));
			w_cfg = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
			if ($urandom_range(7) == 0)
				w_cfg = $urandom_range(9, 64);
			h_cfg = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
			set_frame(CFG_W'(w_cfg), CFG_W'(h_cfg));
			cols   = (w_cfg == 0) ? 1 : w_cfg;
			rows   = (h_cfg == 0) ? 1 : h_cfg;
			frames = (cols * rows > 64) ? 1 : $urandom_range(3, 8);
			repeat (frames) begin
				send_pixels(cols * rows,
					($urandom_range(9) == 0) ? 0 : $urandom_range(1, 100), -1);
				random_sent += cols * rows;
			end
			if ($urandom_range(99) < 20 && cols * rows > 1) begin
				partial = $urandom_range(1, cols * rows - 1);
				send_pixels(partial, 50, -1);
				random_sent += partial;
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("binary_mask_centroid: match");
		end else begin
			$display("binary_mask_centroid: mismatch");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/bmc_pkg.sv
rtl/bmc_ifs.sv
rtl/bmc_front.sv
rtl/bmc_queue.sv
rtl/bmc_back.sv
rtl/binary_mask_centroid.sv
test/tb_binary_mask_centroid.sv
